// File: src/htwd_pkg.sv
// Shared types, constants and helpers of the Huffman tree-walk decoder.
package htwd_pkg;

  localparam int NODE_W      = 9;
  localparam int SLOT_W      = 8;
  localparam int SYM_W       = 8;
  localparam int BYTE_W      = 8;
  localparam int TOTAL_W     = 32;
  localparam int TABLE_DEPTH = 256;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int BITCNT_W    = $clog2(BYTE_W);

  localparam logic [BITCNT_W-1:0] LAST_BIT  = BITCNT_W'(BYTE_W - 1);
  localparam logic [NODE_W-1:0]   ROOT_RST  = 9'd256;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_DATA  = 2'd2;

  localparam logic CFG_ROOT  = 1'b0;
  localparam logic CFG_TOTAL = 1'b1;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_START,
    CMD_DATA
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [SLOT_W-1:0]     slot;
    logic [NODE_W-1:0]     left;
    logic [NODE_W-1:0]     right;
    logic [BYTE_W-1:0]     data;
  } cmd_t;

  function automatic logic is_leaf(input logic [NODE_W-1:0] node,
                                   input logic [NODE_W-1:0] sym_count);
    is_leaf = node < sym_count;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [NODE_W-1:0] node,
                                                input logic [NODE_W-1:0] sym_count);
    logic [NODE_W-1:0] diff;
    diff    = node - sym_count;
    slot_of = diff[SLOT_W-1:0];
  endfunction

endpackage

// File: src/huffman_tree_walk_decoder.sv
// Top level of the Huffman tree-walk decoder with its configuration registers.
//
//  Port group | Direction | Handshake        | Payload
//  in_*       | input     | in_valid/ready   | opcode, node_index, children, data_byte
//  out_*      | output    | out_valid/ready  | symbol, last, done_res
//  cfg_*      | input     | cfg_we           | cfg_index, cfg_data
//
// A live data byte is taken from the queue, the node table is prefetched, the byte is
// walked bit by bit with each step bounded by the dependent table read, and the final
// symbol is handed over. Loads, starts and dead bytes are handled in the idle state.
// A two-entry queue decouples input acceptance from the walker. Reset is synchronous
// and clears control state only; the node table holds no reset value. A waiting result
// stalls the walker when another symbol is ready or the final symbol must be handed over.
module huffman_tree_walk_decoder #(
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic [htwd_pkg::NODE_W-1:0]   in_node_index,
  input  logic [htwd_pkg::NODE_W-1:0]   in_left_child,
  input  logic [htwd_pkg::NODE_W-1:0]   in_right_child,
  input  logic [htwd_pkg::BYTE_W-1:0]   in_data_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [htwd_pkg::SYM_W-1:0]    out_symbol,
  output logic                          out_last,
  output logic                          out_done_res,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [htwd_pkg::TOTAL_W-1:0]  cfg_data
);

  logic [htwd_pkg::NODE_W-1:0]  root_r;
  logic [htwd_pkg::TOTAL_W-1:0] total_r;

  logic           q_push;
  logic           q_ready;
  logic           q_pop;
  logic           q_valid;
  htwd_pkg::cmd_t push_cmd;
  htwd_pkg::cmd_t pop_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r  <= htwd_pkg::ROOT_RST;
      total_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        htwd_pkg::CFG_ROOT: begin
          root_r <= cfg_data[htwd_pkg::NODE_W-1:0];
        end
        htwd_pkg::CFG_TOTAL: begin
          total_r <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  htwd_front #(
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_node_index  (in_node_index),
    .in_left_child  (in_left_child),
    .in_right_child (in_right_child),
    .in_data_byte   (in_data_byte),
    .q_ready        (q_ready),
    .q_push         (q_push),
    .q_cmd          (push_cmd)
  );

  htwd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (push_cmd),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_cmd    (pop_cmd)
  );

  htwd_back #(
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .root_index   (root_r),
    .symbol_total (total_r),
    .q_valid      (q_valid),
    .q_cmd        (pop_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_symbol   (out_symbol),
    .out_last     (out_last),
    .out_done_res (out_done_res)
  );

endmodule

// File: src/htwd_front.sv
// Front end: accepts input transactions and turns them into queue commands, dropping leaf loads and unknown opcodes.
module htwd_front #(
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_opcode,
  input  logic [htwd_pkg::NODE_W-1:0] in_node_index,
  input  logic [htwd_pkg::NODE_W-1:0] in_left_child,
  input  logic [htwd_pkg::NODE_W-1:0] in_right_child,
  input  logic [htwd_pkg::BYTE_W-1:0] in_data_byte,
  input  logic                        q_ready,
  output logic                        q_push,
  output htwd_pkg::cmd_t              q_cmd
);

  localparam logic [htwd_pkg::NODE_W-1:0] SYM_CNT = htwd_pkg::NODE_W'(SYMBOL_COUNT);

  logic keep;

  always_comb begin
    q_cmd.slot  = htwd_pkg::slot_of(in_node_index, SYM_CNT);
    q_cmd.left  = in_left_child;
    q_cmd.right = in_right_child;
    q_cmd.data  = in_data_byte;
    q_cmd.kind  = htwd_pkg::CMD_DATA;
    keep        = 1'b0;
    case (in_opcode)
      htwd_pkg::OP_LOAD: begin
        q_cmd.kind = htwd_pkg::CMD_LOAD;
        keep       = !htwd_pkg::is_leaf(in_node_index, SYM_CNT);
      end
      htwd_pkg::OP_START: begin
        q_cmd.kind = htwd_pkg::CMD_START;
        keep       = 1'b1;
      end
      htwd_pkg::OP_DATA: begin
        q_cmd.kind = htwd_pkg::CMD_DATA;
        keep       = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_ready = q_ready;
  assign q_push   = in_valid && q_ready && keep;

endmodule

// File: src/htwd_queue.sv
// Short command queue between the front end and the tree walker.
module htwd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  htwd_pkg::cmd_t push_cmd,
  output logic           push_ready,
  input  logic           pop,
  output logic           pop_valid,
  output htwd_pkg::cmd_t pop_cmd
);

  htwd_pkg::cmd_t                   entry_r [htwd_pkg::QUEUE_DEPTH];
  logic [htwd_pkg::QPTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [htwd_pkg::QPTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [htwd_pkg::QCNT_W-1:0]      count_r, count_nxt;

  assign push_ready = count_r != htwd_pkg::QCNT_W'(htwd_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_cmd    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == htwd_pkg::QPTR_W'(htwd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == htwd_pkg::QPTR_W'(htwd_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// File: src/htwd_back.sv
// Back end: node table, bit-serial tree walker and result register.
module htwd_back #(
  parameter int SYMBOL_COUNT = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [htwd_pkg::NODE_W-1:0]  root_index,
  input  logic [htwd_pkg::TOTAL_W-1:0] symbol_total,
  input  logic                         q_valid,
  input  htwd_pkg::cmd_t               q_cmd,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [htwd_pkg::SYM_W-1:0]   out_symbol,
  output logic                         out_last,
  output logic                         out_done_res
);

  localparam logic [htwd_pkg::NODE_W-1:0] SYM_CNT = htwd_pkg::NODE_W'(SYMBOL_COUNT);
  localparam int CHILD_W = 2 * htwd_pkg::NODE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREF,
    ST_BIT,
    ST_FLUSH
  } state_t;

  logic [CHILD_W-1:0] node_mem [htwd_pkg::TABLE_DEPTH];

  state_t                          state_r, state_nxt;
  logic [htwd_pkg::NODE_W-1:0]     walk_r, walk_nxt;
  logic [htwd_pkg::TOTAL_W-1:0]    left_r, left_nxt;
  logic [htwd_pkg::BYTE_W-1:0]     byte_r, byte_nxt;
  logic [htwd_pkg::BITCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                            pend_v_r, pend_v_nxt;
  logic [htwd_pkg::SYM_W-1:0]      pend_sym_r, pend_sym_nxt;
  logic                            pend_done_r, pend_done_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [htwd_pkg::SYM_W-1:0]      out_sym_r, out_sym_nxt;
  logic                            out_last_r, out_last_nxt;
  logic                            out_done_r, out_done_nxt;
  logic [CHILD_W-1:0]              rdata_r;

  logic                            can_push;
  logic                            push;
  logic                            hit;
  logic                            stall;
  logic [htwd_pkg::NODE_W-1:0]     child;
  logic [htwd_pkg::NODE_W-1:0]     next_node;
  logic                            rd_en;
  logic [htwd_pkg::SLOT_W-1:0]     rd_addr;
  logic                            mem_we;

  assign can_push  = !out_valid_r || out_ready;
  assign child     = byte_r[htwd_pkg::BYTE_W-1] ? rdata_r[htwd_pkg::NODE_W-1:0]
                                                : rdata_r[CHILD_W-1:htwd_pkg::NODE_W];
  assign next_node = htwd_pkg::is_leaf(walk_r, SYM_CNT) ? walk_r : child;
  assign hit       = htwd_pkg::is_leaf(next_node, SYM_CNT);
  assign stall     = hit && pend_v_r && !can_push;

  always_comb begin
    state_nxt     = state_r;
    walk_nxt      = walk_r;
    left_nxt      = left_r;
    byte_nxt      = byte_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_sym_nxt  = pend_sym_r;
    pend_done_nxt = pend_done_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    rd_en         = 1'b0;
    push          = 1'b0;
    rd_addr       = htwd_pkg::slot_of(walk_r, SYM_CNT);
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            htwd_pkg::CMD_LOAD: begin
              mem_we = 1'b1;
            end
            htwd_pkg::CMD_START: begin
              walk_nxt = root_index;
              left_nxt = symbol_total;
            end
            htwd_pkg::CMD_DATA: begin
              if (left_r != '0) begin
                byte_nxt  = q_cmd.data;
                cnt_nxt   = '0;
                state_nxt = ST_PREF;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_PREF: begin
        rd_en     = 1'b1;
        state_nxt = ST_BIT;
      end
      ST_BIT: begin
        if (!stall) begin
          rd_en    = 1'b1;
          byte_nxt = byte_r << 1;
          cnt_nxt  = cnt_r + 1'b1;
          if (hit) begin
            if (pend_v_r) begin
              push          = 1'b1;
              out_valid_nxt = 1'b1;
              out_sym_nxt   = pend_sym_r;
              out_last_nxt  = 1'b0;
              out_done_nxt  = pend_done_r;
            end
            pend_v_nxt    = 1'b1;
            pend_sym_nxt  = next_node[htwd_pkg::SYM_W-1:0];
            pend_done_nxt = left_r == htwd_pkg::TOTAL_W'(1);
            left_nxt      = left_r - 1'b1;
            walk_nxt      = root_index;
            rd_addr       = htwd_pkg::slot_of(root_index, SYM_CNT);
          end else begin
            walk_nxt = next_node;
            rd_addr  = htwd_pkg::slot_of(next_node, SYM_CNT);
          end
          if (cnt_r == htwd_pkg::LAST_BIT || (hit && left_r == htwd_pkg::TOTAL_W'(1))) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (can_push) begin
          push          = 1'b1;
          out_valid_nxt = 1'b1;
          out_sym_nxt   = pend_sym_r;
          out_last_nxt  = 1'b1;
          out_done_nxt  = pend_done_r;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      walk_r      <= htwd_pkg::ROOT_RST;
      left_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      walk_r      <= walk_nxt;
      left_r      <= left_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    byte_r      <= byte_nxt;
    cnt_r       <= cnt_nxt;
    pend_sym_r  <= pend_sym_nxt;
    pend_done_r <= pend_done_nxt;
    out_sym_r   <= out_sym_nxt;
    out_last_r  <= out_last_nxt;
    out_done_r  <= out_done_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[q_cmd.slot] <= {q_cmd.left, q_cmd.right};
    end
    if (rd_en) begin
      rdata_r <= node_mem[rd_addr];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_symbol   = out_sym_r;
  assign out_last     = out_last_r;
  assign out_done_res = out_done_r;

  a_bit_has_budget: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BIT |-> left_r != '0)
    else $error("Walker is consuming bits with no symbols left.");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !pend_v_r)
    else $error("A symbol is still pending while the walker is idle.");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> can_push)
    else $error("Result register overwritten before its transaction completed.");

  a_data_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE && q_valid && q_cmd.kind == htwd_pkg::CMD_DATA && left_r != '0
    |=> state_r == ST_PREF)
    else $error("A live data byte did not start a walk.");

endmodule

// File: verif/tb_huffman_tree_walk_decoder.sv
// Self-checking testbench that decodes every accepted transaction with its own tree walker.
module tb_huffman_tree_walk_decoder;

  localparam int SYMBOL_COUNT = 256;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [1:0] OP_NOP = 2'd3;

  typedef logic [htwd_pkg::NODE_W-1:0]  node_t;
  typedef logic [htwd_pkg::SLOT_W-1:0]  slot_t;
  typedef logic [htwd_pkg::BYTE_W-1:0]  byte_t;
  typedef logic [htwd_pkg::TOTAL_W-1:0] count_t;

  localparam node_t FIRST_NODE = node_t'(SYMBOL_COUNT);

  typedef struct packed {
    logic [htwd_pkg::SYM_W-1:0] symbol;
    logic                       last;
    logic                       done_res;
  } decoded_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_valid;
  logic         in_ready;
  logic [1:0]   in_opcode;
  node_t        in_node_index;
  node_t        in_left_child;
  node_t        in_right_child;
  byte_t        in_data_byte;
  logic         out_valid;
  logic         out_ready = 1'b1;
  logic [htwd_pkg::SYM_W-1:0] out_symbol;
  logic         out_last;
  logic         out_done_res;
  logic         cfg_we;
  logic         cfg_index;
  count_t       cfg_data;

  node_t    child_left [htwd_pkg::TABLE_DEPTH];
  node_t    child_right [htwd_pkg::TABLE_DEPTH];
  bit       slot_written [htwd_pkg::TABLE_DEPTH];
  node_t    written_nodes[$];
  node_t    root_sel;
  node_t    walker;
  count_t   total_sel;
  count_t   symbols_remaining;
  decoded_t expected_symbols[$];
  decoded_t want;
  decoded_t got;
  int       errors = 0;
  bit       idling = 1'b1;
  int       stall_left = 0;

  huffman_tree_walk_decoder #(
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_opcode     (in_opcode),
    .in_node_index (in_node_index),
    .in_left_child (in_left_child),
    .in_right_child(in_right_child),
    .in_data_byte  (in_data_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_symbol    (out_symbol),
    .out_last      (out_last),
    .out_done_res  (out_done_res),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (idling && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got = '{out_symbol, out_last, out_done_res};
      if (expected_symbols.size() == 0) begin
        $display("%0t: expected none, actual symbol=%0d last=%0b done_res=%0b",
                 $time, got.symbol, got.last, got.done_res);
        errors++;
      end else begin
        want = expected_symbols.pop_front();
        if (got !== want) begin
          $display("%0t: expected symbol=%0d last=%0b done_res=%0b, %s=%0d last=%0b done_res=%0b",
                   $time, want.symbol, want.last, want.done_res, "actual symbol",
                   got.symbol, got.last, got.done_res);
          errors++;
        end
      end
    end
  end

  task automatic decode_transaction(input logic [1:0] op, input node_t node, input node_t left,
                                    input node_t right, input byte_t data);
    node_t    nxt;
    slot_t    slot;
    decoded_t res;
    int       produced;
    produced = 0;
    case (op)
      htwd_pkg::OP_LOAD: begin
        if (node >= FIRST_NODE) begin
          slot = slot_t'(node - FIRST_NODE);
          if (!slot_written[slot]) begin
            written_nodes.push_back(node);
          end
          slot_written[slot] = 1'b1;
          child_left[slot] = left;
          child_right[slot] = right;
        end
      end
      htwd_pkg::OP_START: begin
        walker = root_sel;
        symbols_remaining = total_sel;
      end
      htwd_pkg::OP_DATA: begin
        for (int b = htwd_pkg::BYTE_W - 1; b >= 0; b--) begin
          if (symbols_remaining == 0) break;
          if (walker < FIRST_NODE) begin
            nxt = walker;
          end else begin
            slot = slot_t'(walker - FIRST_NODE);
            nxt = data[b] ? child_right[slot] : child_left[slot];
          end
          if (nxt < FIRST_NODE) begin
            symbols_remaining = symbols_remaining - 1;
            res.symbol = nxt[htwd_pkg::SYM_W-1:0];
            res.last = 1'b0;
            res.done_res = (symbols_remaining == 0);
            expected_symbols.push_back(res);
            produced++;
            walker = root_sel;
          end else begin
            walker = nxt;
          end
        end
      end
      default: ;
    endcase
    if (produced > 0) begin
      res = expected_symbols.pop_back();
      res.last = 1'b1;
      expected_symbols.push_back(res);
    end
  endtask

  task automatic send_item(input logic [1:0] op, input node_t node, input node_t left,
                           input node_t right, input byte_t data);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_node_index <= node;
    in_left_child <= left;
    in_right_child <= right;
    in_data_byte <= data;
    do @(posedge clk); while (!in_ready);
    decode_transaction(op, node, left, right, data);
  endtask

  function automatic node_t any_node();
    return node_t'($urandom);
  endfunction

  function automatic node_t random_child();
    if ($urandom_range(0, 2) == 0) begin
      return written_nodes[$urandom_range(0, written_nodes.size() - 1)];
    end
    return node_t'($urandom_range(0, SYMBOL_COUNT - 1));
  endfunction

  task automatic send_load(input node_t node, input node_t left, input node_t right);
    send_item(htwd_pkg::OP_LOAD, node, left, right, byte_t'($urandom));
  endtask

  task automatic send_start();
    send_item(htwd_pkg::OP_START, any_node(), any_node(), any_node(), byte_t'($urandom));
  endtask

  task automatic send_byte(input byte_t data);
    send_item(htwd_pkg::OP_DATA, any_node(), any_node(), any_node(), data);
  endtask

  task automatic wait_drained(input int extra);
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_symbols.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_registers(input node_t root, input count_t total);
    cfg_we <= 1'b1;
    cfg_index <= htwd_pkg::CFG_ROOT;
    cfg_data <= count_t'(root);
    @(posedge clk);
    cfg_index <= htwd_pkg::CFG_TOTAL;
    cfg_data <= total;
    @(posedge clk);
    cfg_we <= 1'b0;
    root_sel = root;
    total_sel = total;
  endtask

  task automatic test_data_before_start();
    send_load(FIRST_NODE, 9'd3, 9'd4);
    send_byte(8'hFF);
    send_item(OP_NOP, any_node(), any_node(), any_node(), 8'h5A);
  endtask

  task automatic test_fixed_tree();
    send_load(9'd257, 9'd0, 9'd255);
    send_load(9'd511, 9'd1, 9'd300);
    send_load(9'd300, 9'd7, 9'd200);
    send_load(9'd256, 9'd257, 9'd511);
    send_load(9'd100, 9'd511, 9'd511);
    wait_drained(SETTLE_CYCLES);
    set_registers(9'd256, 32'd20);
    send_start();
    send_byte(8'h1B);
    send_byte(8'h07);
    send_byte(8'h00);
    wait_drained(SETTLE_CYCLES);
    set_registers(9'd256, 32'd5);
    send_start();
    send_byte(8'h1B);
    send_byte(8'hFF);
    send_byte(8'h00);
  endtask

  task automatic test_register_extremes();
    wait_drained(SETTLE_CYCLES);
    set_registers(9'd511, 32'd3);
    send_start();
    send_byte(8'hA5);
    send_byte(8'h3C);
    wait_drained(SETTLE_CYCLES);
    set_registers(9'd256, 32'd0);
    send_start();
    send_byte(8'hFF);
  endtask

  task automatic test_leaf_root();
    wait_drained(SETTLE_CYCLES);
    set_registers(9'd255, 32'hFFFF_FFFF);
    send_start();
    send_byte(8'hA5);
    wait_drained(SETTLE_CYCLES);
    set_registers(9'd0, 32'd10);
    send_start();
    send_byte(8'hFF);
    send_byte(8'h0F);
  endtask

  task automatic run_random_phase(input int n_items);
    node_t  root;
    count_t total;
    int     pick;
    wait_drained(SETTLE_CYCLES);
    root = written_nodes[$urandom_range(0, written_nodes.size() - 1)];
    if ($urandom_range(0, 7) == 0) begin
      root = node_t'(root[htwd_pkg::SLOT_W-1:0]);
    end
    case ($urandom_range(0, 5))
      0: total = '1;
      1: total = count_t'($urandom);
      default: total = count_t'($urandom_range(20, 200));
    endcase
    set_registers(root, total);
    send_start();
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) begin
        wait_drained(0);
      end
      pick = $urandom_range(0, 99);
      if (symbols_remaining == 0 && pick < 60) begin
        send_start();
      end else if (pick < 12) begin
        send_load(node_t'($urandom_range(SYMBOL_COUNT, 511)), random_child(), random_child());
      end else if (pick < 15) begin
        send_item(OP_NOP, any_node(), any_node(), any_node(), byte_t'($urandom));
      end else if (pick < 18) begin
        send_load(node_t'($urandom_range(0, SYMBOL_COUNT - 1)), any_node(), any_node());
      end else if (pick < 21) begin
        send_start();
      end else begin
        send_byte(byte_t'($urandom));
      end
    end
  endtask

  task automatic test_random_streams();
    for (int p = 0; p < 6; p++) begin
      idling = (p != 2);
      run_random_phase(26);
    end
  endtask

  task automatic test_quiet_tail();
    idling = 1'b0;
    run_random_phase(40);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_opcode <= htwd_pkg::OP_LOAD;
    in_node_index <= '0;
    in_left_child <= '0;
    in_right_child <= '0;
    in_data_byte <= '0;
    cfg_we <= 1'b0;
    cfg_index <= htwd_pkg::CFG_ROOT;
    cfg_data <= '0;
    root_sel = htwd_pkg::ROOT_RST;
    walker = htwd_pkg::ROOT_RST;
    total_sel = '0;
    symbols_remaining = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_data_before_start();
    test_fixed_tree();
    test_register_extremes();
    test_leaf_root();
    test_random_streams();
    test_quiet_tail();
    wait_drained(SETTLE_CYCLES);
    if (errors == 0) begin
      $display("tb_huffman_tree_walk_decoder OK");
    end else begin
      $display("tb_huffman_tree_walk_decoder NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_huffman_tree_walk_decoder NOT OK");
    $finish;
  end

endmodule
